### rtl/rses_pkg.sv
// ============================================================================
// rses_pkg: shared types and constants of the relative error servo step
// Widths, microcode formats, the microcode table and the register layout.
// ============================================================================
package rses_pkg;

   localparam int DataBits     = 16;
   localparam int SampleBits   = 16;
   localparam int LimitBits    = 8;
   localparam int CsrIndexBits = 3;
   localparam int StatusBits   = 3;
   localparam int TolFracBits  = DataBits;
   localparam int MagBits      = (SampleBits > DataBits) ? SampleBits : DataBits;
   localparam int DiffBits     = MagBits + 1;
   localparam int ProdBits     = DataBits + MagBits;
   localparam int GainShift    = 6;
   localparam int NumBits      = ProdBits + GainShift;
   localparam int DivBits      = DataBits + 2;
   localparam int QuoBits      = MagBits + 1;
   localparam int CountBits    = $clog2(QuoBits);
   localparam int SumBits      = QuoBits + 2;
   localparam int StepBits     = 3;

   localparam logic [QuoBits-1:0] MaxStepCounts = QuoBits'(164);

   localparam logic OPER_START  = 1'b0;
   localparam logic OPER_SAMPLE = 1'b1;

   typedef enum logic [StatusBits-1:0] {
      ST_STARTED,
      ST_ADJUST,
      ST_LOCKED,
      ST_FAILED,
      ST_MON_OK,
      ST_MON_DRIFT,
      ST_IGNORED
   } status_type;

   typedef enum logic [CsrIndexBits-1:0] {
      CSR_SET_POINT,
      CSR_TOLERANCE,
      CSR_GAIN,
      CSR_DRIVE_MIN,
      CSR_DRIVE_MAX,
      CSR_INITIAL_DRIVE,
      CSR_ATTEMPT_LIMIT,
      CSR_MONITOR_ONLY
   } csr_index_type;

   typedef enum logic [2:0] {
      UOP_LOAD,
      UOP_MUL_TOL,
      UOP_CHK_TOL,
      UOP_MUL_GAIN,
      UOP_DIV_INIT,
      UOP_DIV_STEP,
      UOP_ADD,
      UOP_WRITE_BACK
   } uop_type;

   typedef enum logic [2:0] {
      COND_NONE,
      COND_NO_REQ,
      COND_SKIP,
      COND_NO_ADJUST,
      COND_DIV_EARLY,
      COND_COUNT_NZ,
      COND_OUT_BUSY
   } cond_type;

   typedef logic [StepBits-1:0] step_type;

   localparam step_type STEP_LOAD       = StepBits'(0);
   localparam step_type STEP_MUL_TOL    = StepBits'(1);
   localparam step_type STEP_CHK_TOL    = StepBits'(2);
   localparam step_type STEP_MUL_GAIN   = StepBits'(3);
   localparam step_type STEP_DIV_INIT   = StepBits'(4);
   localparam step_type STEP_DIV_STEP   = StepBits'(5);
   localparam step_type STEP_ADD        = StepBits'(6);
   localparam step_type STEP_WRITE_BACK = StepBits'(7);

   typedef struct packed {
      uop_type  op;
      cond_type cond;
      step_type target;
   } ucode_type;

   typedef struct packed {
      uop_type op;
      logic    load;
   } ctrl_type;

   typedef struct packed {
      logic skip;
      logic no_adjust;
      logic div_early;
      logic count_nz;
      logic out_busy;
   } flags_type;

   typedef struct packed {
      logic signed [DataBits-1:0] set_point;
      logic [DataBits-1:0]        tolerance;
      logic [DataBits-1:0]        gain;
      logic signed [DataBits-1:0] drive_min;
      logic signed [DataBits-1:0] drive_max;
      logic signed [DataBits-1:0] initial_drive;
      logic [LimitBits-1:0]       attempt_limit;
      logic                       monitor_only;
   } cfg_type;

   localparam cfg_type CfgReset = '{
      set_point:     DataBits'(16384),
      tolerance:     DataBits'(655),
      gain:          DataBits'(256),
      drive_min:     DataBits'(-32768),
      drive_max:     DataBits'(32767),
      initial_drive: '0,
      attempt_limit: LimitBits'(100),
      monitor_only:  1'b0
   };

   // The step after the write-back wraps to the load step.
   function automatic ucode_type ucode_rom(input step_type step);
      ucode_type w;
      case (step)
         STEP_LOAD:       w = '{UOP_LOAD,       COND_NO_REQ,    STEP_LOAD};
         STEP_MUL_TOL:    w = '{UOP_MUL_TOL,    COND_SKIP,      STEP_WRITE_BACK};
         STEP_CHK_TOL:    w = '{UOP_CHK_TOL,    COND_NO_ADJUST, STEP_WRITE_BACK};
         STEP_MUL_GAIN:   w = '{UOP_MUL_GAIN,   COND_NONE,      STEP_LOAD};
         STEP_DIV_INIT:   w = '{UOP_DIV_INIT,   COND_DIV_EARLY, STEP_ADD};
         STEP_DIV_STEP:   w = '{UOP_DIV_STEP,   COND_COUNT_NZ,  STEP_DIV_STEP};
         STEP_ADD:        w = '{UOP_ADD,        COND_NONE,      STEP_LOAD};
         STEP_WRITE_BACK: w = '{UOP_WRITE_BACK, COND_OUT_BUSY,  STEP_WRITE_BACK};
         default:         w = '{UOP_WRITE_BACK, COND_OUT_BUSY,  STEP_WRITE_BACK};
      endcase
      return w;
   endfunction

endpackage

### rtl/rses_ifs.sv
// ============================================================================
// rses channel interfaces
// Valid and ready channels for request, response and register writes.
// ============================================================================
interface rses_req_if;
   import rses_pkg::*;
   logic                         valid;
   logic                         ready;
   logic                         operation;
   logic signed [SampleBits-1:0] sample;
   modport source (output valid, operation, sample, input ready);
   modport sink (input valid, operation, sample, output ready);
endinterface

interface rses_rsp_if;
   import rses_pkg::*;
   logic                       valid;
   logic                       ready;
   logic signed [DataBits-1:0] drive_value;
   logic signed [DataBits-1:0] measured_value;
   logic [StatusBits-1:0]      status;
   logic                       finished;
   modport source (output valid, drive_value, measured_value, status, finished,
                   input ready);
   modport sink (input valid, drive_value, measured_value, status, finished,
                 output ready);
endinterface

interface rses_csr_if;
   import rses_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [CsrIndexBits-1:0] index;
   logic [DataBits-1:0]     data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

### rtl/rses_csr.sv
// ============================================================================
// rses_csr: configuration register file
// Holds the servo settings and takes one register write per word.
// ============================================================================
module rses_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   input  logic [rses_pkg::CsrIndexBits-1:0] csr_index,
   input  logic [rses_pkg::DataBits-1:0]     csr_data,
   output logic                              csr_ready,
   output rses_pkg::cfg_type                 cfg
);
   import rses_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = !reset;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_SET_POINT:     cfg_in.set_point     = $signed(csr_data);
            CSR_TOLERANCE:     cfg_in.tolerance     = csr_data;
            CSR_GAIN:          cfg_in.gain          = csr_data;
            CSR_DRIVE_MIN:     cfg_in.drive_min     = $signed(csr_data);
            CSR_DRIVE_MAX:     cfg_in.drive_max     = $signed(csr_data);
            CSR_INITIAL_DRIVE: cfg_in.initial_drive = $signed(csr_data);
            CSR_ATTEMPT_LIMIT: cfg_in.attempt_limit = csr_data[LimitBits-1:0];
            CSR_MONITOR_ONLY:  cfg_in.monitor_only  = csr_data[0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CfgReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### rtl/rses_useq.sv
// ============================================================================
// rses_useq: microcode sequencer
// Step counter over the control table with conditional jumps.
// ============================================================================
module rses_useq (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  rses_pkg::flags_type flags,
   output logic                req_ready,
   output rses_pkg::ctrl_type  ctrl
);
   import rses_pkg::*;

   step_type  pc_ff;
   step_type  pc_in;
   ucode_type word;
   logic      jump;

   assign word = ucode_rom(pc_ff);

   always_comb begin
      case (word.cond)
         COND_NONE:      jump = 1'b0;
         COND_NO_REQ:    jump = !req_valid;
         COND_SKIP:      jump = flags.skip;
         COND_NO_ADJUST: jump = flags.no_adjust;
         COND_DIV_EARLY: jump = flags.div_early;
         COND_COUNT_NZ:  jump = flags.count_nz;
         COND_OUT_BUSY:  jump = flags.out_busy;
         default:        jump = 1'b0;
      endcase
      pc_in = jump ? word.target : pc_ff + StepBits'(1);
   end

   always_comb begin
      req_ready = (word.op == UOP_LOAD) && !reset;
      ctrl.op   = word.op;
      ctrl.load = req_ready && req_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= STEP_LOAD;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

### rtl/rses_dpath.sv
// ============================================================================
// rses_dpath: servo datapath
// Shared multiplier, serial divider, clamp, servo state and result register.
// ============================================================================
module rses_dpath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  rses_pkg::ctrl_type                    ctrl,
   input  rses_pkg::cfg_type                     cfg,
   input  logic                                  req_operation,
   input  logic signed [rses_pkg::SampleBits-1:0] req_sample,
   input  logic                                  rsp_ready,
   output logic                                  rsp_valid,
   output logic signed [rses_pkg::DataBits-1:0]  rsp_drive_value,
   output logic signed [rses_pkg::DataBits-1:0]  rsp_measured_value,
   output logic [rses_pkg::StatusBits-1:0]       rsp_status,
   output logic                                  rsp_finished,
   output rses_pkg::flags_type                   flags
);
   import rses_pkg::*;

   logic                         oper_ff;
   logic signed [SampleBits-1:0] sample_ff;
   logic [DataBits-1:0]          sp_mag_ff;
   logic [DataBits-1:0]          sp_mag_in;
   logic                         sp_neg_ff;
   logic                         sp_neg_in;
   logic [MagBits-1:0]           diff_mag_ff;
   logic [MagBits-1:0]           diff_mag_in;
   logic                         diff_neg_ff;
   logic                         diff_neg_in;
   logic signed [DataBits:0]     sp_wide;
   logic signed [DataBits:0]     sp_abs;
   logic signed [DiffBits-1:0]   diff;
   logic signed [DiffBits-1:0]   diff_abs;

   logic [DivBits-1:0]           div_ff;
   logic [DivBits-1:0]           div_in;
   logic [DataBits-1:0]          mul_a;
   logic [MagBits-1:0]           mul_b;
   logic [ProdBits-1:0]          mul_out;
   logic [ProdBits-1:0]          prod_ff;
   logic [ProdBits-1:0]          prod_in;
   logic                         in_tol;
   logic                         in_tol_ff;
   logic                         in_tol_in;

   logic [NumBits-1:0]           num;
   logic [NumBits-QuoBits-1:0]   num_hi;
   logic                         ovf_now;
   logic                         zero_now;
   logic                         ovf_ff;
   logic                         ovf_in;
   logic                         zero_ff;
   logic                         zero_in;
   logic [DivBits-1:0]           rem_ff;
   logic [DivBits-1:0]           rem_in;
   logic [QuoBits-1:0]           quo_ff;
   logic [QuoBits-1:0]           quo_in;
   logic [CountBits-1:0]         count_ff;
   logic [CountBits-1:0]         count_in;
   logic [DivBits:0]             trial;
   logic [DivBits:0]             trial_diff;
   logic                         trial_ge;

   logic [QuoBits-1:0]           step_mag;
   logic [QuoBits-1:0]           step_pos;
   logic signed [QuoBits:0]      step_val;
   logic signed [SumBits-1:0]    sum_ff;
   logic signed [SumBits-1:0]    sum_in;
   logic signed [SumBits-1:0]    hi_ext;
   logic signed [SumBits-1:0]    lo_ext;
   logic signed [SumBits-1:0]    clamp_hi;
   logic signed [SumBits-1:0]    clamp;

   logic signed [DataBits-1:0]   drive_ff;
   logic signed [DataBits-1:0]   drive_in;
   logic signed [DataBits-1:0]   drive_wb;
   logic [LimitBits-1:0]         attempts_ff;
   logic [LimitBits-1:0]         attempts_in;
   logic [LimitBits-1:0]         attempts_wb;
   logic [LimitBits-1:0]         attempts_next;
   logic [LimitBits-1:0]         limit_eff;
   logic                         run_done_ff;
   logic                         run_done_in;
   logic                         run_done_wb;
   logic [SampleBits-1:0]        last_ff;
   logic [SampleBits-1:0]        last_in;
   logic [SampleBits-1:0]        last_wb;
   status_type                   status_wb;
   logic                         fin_wb;

   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;
   logic signed [DataBits-1:0]   rsp_drive_ff;
   logic signed [DataBits-1:0]   rsp_meas_ff;
   status_type                   rsp_status_ff;
   logic                         rsp_fin_ff;
   logic                         out_busy;
   logic                         wb_fire;

   // Operand magnitudes and signs for the request being loaded.
   always_comb begin
      sp_wide     = (DataBits + 1)'(cfg.set_point);
      sp_neg_in   = cfg.set_point[DataBits-1];
      sp_abs      = sp_neg_in ? -sp_wide : sp_wide;
      sp_mag_in   = sp_abs[DataBits-1:0];
      diff        = DiffBits'(cfg.set_point) - DiffBits'(req_sample);
      diff_neg_in = diff[DiffBits-1];
      diff_abs    = diff_neg_in ? -diff : diff;
      diff_mag_in = diff_abs[MagBits-1:0];
   end

   // The multiplier serves both the tolerance bound and the gain product.
   always_comb begin
      mul_a   = (ctrl.op == UOP_MUL_GAIN) ? cfg.gain : cfg.tolerance;
      mul_b   = (ctrl.op == UOP_MUL_GAIN) ? diff_mag_ff : MagBits'(sp_mag_ff);
      mul_out = ProdBits'(mul_a) * ProdBits'(mul_b);
      in_tol  = {diff_mag_ff, {TolFracBits{1'b0}}} < prod_ff;
   end

   // A quotient that does not fit in QuoBits saturates; a zero divisor lands here too.
   always_comb begin
      num        = {prod_ff, {GainShift{1'b0}}};
      num_hi     = num[NumBits-1:QuoBits];
      ovf_now    = num_hi >= (NumBits - QuoBits)'(div_ff);
      zero_now   = (prod_ff == '0);
      trial      = {rem_ff, quo_ff[QuoBits-1]};
      trial_diff = trial - {1'b0, div_ff};
      trial_ge   = trial >= {1'b0, div_ff};
   end

   always_comb begin
      step_mag = zero_ff ? '0 : (ovf_ff ? '1 : quo_ff);
      step_pos = (step_mag > MaxStepCounts) ? MaxStepCounts : step_mag;
      step_val = (diff_neg_ff ^ sp_neg_ff) ? -$signed({1'b0, step_mag})
                                           : $signed({1'b0, step_pos});
      hi_ext   = SumBits'(cfg.drive_max);
      lo_ext   = SumBits'(cfg.drive_min);
      clamp_hi = (sum_ff > hi_ext) ? hi_ext : sum_ff;
      clamp    = (clamp_hi < lo_ext) ? lo_ext : clamp_hi;
   end

   always_comb begin
      attempts_next = attempts_ff + LimitBits'(1);
      limit_eff     = (cfg.attempt_limit == '0) ? LimitBits'(1) : cfg.attempt_limit;
      drive_wb      = drive_ff;
      attempts_wb   = attempts_ff;
      run_done_wb   = run_done_ff;
      last_wb       = last_ff;
      status_wb     = ST_IGNORED;
      fin_wb        = 1'b0;
      if (oper_ff == OPER_START) begin
         if (!cfg.monitor_only) begin
            drive_wb = cfg.initial_drive;
         end
         attempts_wb = '0;
         run_done_wb = 1'b0;
         status_wb   = ST_STARTED;
      end else if (!run_done_ff) begin
         last_wb = sample_ff;
         if (cfg.monitor_only) begin
            run_done_wb = 1'b1;
            status_wb   = in_tol_ff ? ST_MON_OK : ST_MON_DRIFT;
            fin_wb      = 1'b1;
         end else begin
            attempts_wb = attempts_next;
            if (in_tol_ff) begin
               run_done_wb = 1'b1;
               status_wb   = ST_LOCKED;
               fin_wb      = 1'b1;
            end else begin
               drive_wb = clamp[DataBits-1:0];
               if (attempts_next >= limit_eff) begin
                  run_done_wb = 1'b1;
                  status_wb   = ST_FAILED;
                  fin_wb      = 1'b1;
               end else begin
                  status_wb = ST_ADJUST;
               end
            end
         end
      end
   end

   always_comb begin
      out_busy     = rsp_valid_ff && !rsp_ready;
      wb_fire      = (ctrl.op == UOP_WRITE_BACK) && !out_busy;
      rsp_valid_in = wb_fire ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
      drive_in     = wb_fire ? drive_wb : drive_ff;
      attempts_in  = wb_fire ? attempts_wb : attempts_ff;
      run_done_in  = wb_fire ? run_done_wb : run_done_ff;
      last_in      = wb_fire ? last_wb : last_ff;
   end

   always_comb begin
      prod_in   = prod_ff;
      div_in    = div_ff;
      in_tol_in = in_tol_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      count_in  = count_ff;
      ovf_in    = ovf_ff;
      zero_in   = zero_ff;
      sum_in    = sum_ff;
      case (ctrl.op)
         UOP_MUL_TOL: begin
            prod_in = mul_out;
            div_in  = DivBits'(sp_mag_ff) + (DivBits'(sp_mag_ff) << 2);
         end
         UOP_CHK_TOL: begin
            in_tol_in = in_tol;
         end
         UOP_MUL_GAIN: begin
            prod_in = mul_out;
         end
         UOP_DIV_INIT: begin
            rem_in   = num_hi[DivBits-1:0];
            quo_in   = num[QuoBits-1:0];
            count_in = CountBits'(QuoBits - 1);
            ovf_in   = ovf_now;
            zero_in  = zero_now;
         end
         UOP_DIV_STEP: begin
            rem_in   = trial_ge ? trial_diff[DivBits-1:0] : trial[DivBits-1:0];
            quo_in   = {quo_ff[QuoBits-2:0], trial_ge};
            count_in = count_ff - CountBits'(1);
         end
         UOP_ADD: begin
            sum_in = SumBits'(drive_ff) + SumBits'(step_val);
         end
         default: begin
            sum_in = sum_ff;
         end
      endcase
   end

   always_comb begin
      flags.skip      = (oper_ff != OPER_SAMPLE) || run_done_ff;
      flags.no_adjust = cfg.monitor_only || in_tol;
      flags.div_early = ovf_now || zero_now;
      flags.count_nz  = (count_ff != '0);
      flags.out_busy  = out_busy;
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         oper_ff     <= req_operation;
         sample_ff   <= req_sample;
         sp_mag_ff   <= sp_mag_in;
         sp_neg_ff   <= sp_neg_in;
         diff_mag_ff <= diff_mag_in;
         diff_neg_ff <= diff_neg_in;
      end
      prod_ff   <= prod_in;
      div_ff    <= div_in;
      in_tol_ff <= in_tol_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      count_ff  <= count_in;
      ovf_ff    <= ovf_in;
      zero_ff   <= zero_in;
      sum_ff    <= sum_in;
      if (wb_fire) begin
         rsp_drive_ff  <= drive_wb;
         rsp_meas_ff   <= DataBits'(last_wb);
         rsp_status_ff <= status_wb;
         rsp_fin_ff    <= fin_wb;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         drive_ff     <= '0;
         attempts_ff  <= '0;
         run_done_ff  <= 1'b1;
         last_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         drive_ff     <= drive_in;
         attempts_ff  <= attempts_in;
         run_done_ff  <= run_done_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_drive_value    = rsp_drive_ff;
   assign rsp_measured_value = rsp_meas_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_finished       = rsp_fin_ff;

endmodule

### rtl/relative_error_servo_step.sv
// ============================================================================
// relative_error_servo_step: proportional servo step on relative error
// A start word opens a calibration run; each sample word yields one result
// word with the new drive, the last sample that was not ignored, a status and a finished flag.
// The req_bus channel takes one word when its valid and ready are both high,
// and ready is high only while the sequencer sits on its load step out of reset.
// The rsp_bus channel holds each result in an output register until taken.
// The csr_bus channel is ready whenever reset is low and writes one register per word.
// The next word is taken in the cycle after the result is written, so a word
// is fully processed, through the serial divider for an adjusting sample,
// before the next one is accepted.
// A stalled receiver holds the result; the sequencer finishes the next word
// and then waits on its write-back step until the output register is free.
// Reset loads the register defaults, clears the drive and the valid flag of the result
// register, and leaves the servo idle until a start word arrives.
// ============================================================================
module relative_error_servo_step (
   input logic         clock,
   input logic         reset,
   rses_req_if.sink    req_bus,
   rses_rsp_if.source  rsp_bus,
   rses_csr_if.sink    csr_bus
);
   import rses_pkg::*;

   cfg_type   cfg;
   ctrl_type  ctrl;
   flags_type flags;

   rses_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_bus.valid),
      .csr_index (csr_bus.index),
      .csr_data  (csr_bus.data),
      .csr_ready (csr_bus.ready),
      .cfg       (cfg)
   );

   rses_useq u_useq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .flags     (flags),
      .req_ready (req_bus.ready),
      .ctrl      (ctrl)
   );

   rses_dpath u_dpath (
      .clock              (clock),
      .reset              (reset),
      .ctrl               (ctrl),
      .cfg                (cfg),
      .req_operation      (req_bus.operation),
      .req_sample         (req_bus.sample),
      .rsp_ready          (rsp_bus.ready),
      .rsp_valid          (rsp_bus.valid),
      .rsp_drive_value    (rsp_bus.drive_value),
      .rsp_measured_value (rsp_bus.measured_value),
      .rsp_status         (rsp_bus.status),
      .rsp_finished       (rsp_bus.finished),
      .flags              (flags)
   );

endmodule

### rtl/rses_checker.sv
// ============================================================================
// rses_checker: port level checks of the servo step
// Watches the result channel and is bound to the top level.
// ============================================================================
module rses_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic signed [rses_pkg::DataBits-1:0] rsp_drive_value,
   input logic signed [rses_pkg::DataBits-1:0] rsp_measured_value,
   input logic [rses_pkg::StatusBits-1:0]      rsp_status,
   input logic                                 rsp_finished
);
   import rses_pkg::*;

   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word present after reset");

   a_finish_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_finished |->
         (rsp_status == ST_LOCKED) || (rsp_status == ST_FAILED) ||
         (rsp_status == ST_MON_OK) || (rsp_status == ST_MON_DRIFT))
      else $error("finished word carries a status that does not end a run");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_drive_value) &&
         $stable(rsp_measured_value) && $stable(rsp_status) && $stable(rsp_finished))
      else $error("stalled result word changed");

endmodule

bind relative_error_servo_step rses_checker u_rses_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_bus.valid),
   .rsp_ready          (rsp_bus.ready),
   .rsp_drive_value    (rsp_bus.drive_value),
   .rsp_measured_value (rsp_bus.measured_value),
   .rsp_status         (rsp_bus.status),
   .rsp_finished       (rsp_bus.finished)
);
